>>> src/length_prefixed_frame_deframer_unit_assert.svh
// Assertion macros shared by the deframer RTL files.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent holds in a cycle: consequent holds in the same cycle.
`define LPFD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");
// Antecedent holds in a cycle: consequent holds in the next cycle.
`define LPFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");
`else
`define LPFD_ASSERT_SAME(label, clk, rst, ante, cons)
`define LPFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/lpfd_pkg.sv
// Types and constants of the length-prefixed frame deframer.
`timescale 1ns / 1ps
package lpfd_pkg;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   localparam logic [7:0] LONG_MARK         = 8'hff;
   localparam logic [7:0] FLAG_MORE         = 8'd1;
   localparam logic [3:0] SHORT_FLAGS_COUNT = 4'd1;
   localparam logic [3:0] LONG_FLAGS_COUNT  = 4'd9;

   typedef struct packed {
      logic          valid;
      kind_type      kind;
      logic [7:0]    payload;
      logic [63:0]   length;
      logic          more;
      logic          last;
   } result_type;

endpackage

>>> src/lpfd_parser.sv
// Frame header and payload parser: holds the parse state, decodes one byte per step.
`timescale 1ns / 1ps
`include "length_prefixed_frame_deframer_unit_assert.svh"
module lpfd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             stream_byte,
   output lpfd_pkg::result_type   result
);

   logic        in_payload_ff, in_payload_in;
   logic [3:0]  header_count_ff, header_count_in;
   logic        long_form_ff, long_form_in;
   logic [63:0] size_accum_ff, size_accum_in;
   logic [63:0] remaining_ff, remaining_in;

   logic        hdr_long;
   logic [3:0]  hdr_count;
   logic [63:0] hdr_accum;
   logic        do_finish;
   logic        do_first;

   always_comb begin
      result          = '0;
      result.kind     = lpfd_pkg::KIND_HEADER;
      in_payload_in   = in_payload_ff;
      header_count_in = header_count_ff;
      long_form_in    = long_form_ff;
      size_accum_in   = size_accum_ff;
      remaining_in    = remaining_ff;
      do_finish       = 1'b0;
      do_first        = 1'b0;
      // a payload state with nothing left restarts the header
      hdr_long  = in_payload_ff ? 1'b0 : long_form_ff;
      hdr_count = in_payload_ff ? 4'd0 : header_count_ff;
      hdr_accum = in_payload_ff ? 64'd0 : size_accum_ff;

      if (in_payload_ff && remaining_ff != 64'd0) begin
         result.valid   = 1'b1;
         result.kind    = lpfd_pkg::KIND_PAYLOAD;
         result.payload = stream_byte;
         result.last    = (remaining_ff == 64'd1);
         remaining_in   = remaining_ff - 64'd1;
         if (remaining_ff == 64'd1) begin
            in_payload_in   = 1'b0;
            header_count_in = 4'd0;
            long_form_in    = 1'b0;
            size_accum_in   = 64'd0;
         end
      end else if (hdr_count == 4'd0) begin
         do_first = 1'b1;
      end else if (!hdr_long) begin
         if (hdr_count == lpfd_pkg::SHORT_FLAGS_COUNT) do_finish = 1'b1;
         else do_first = 1'b1;
      end else if (hdr_count < lpfd_pkg::LONG_FLAGS_COUNT) begin
         in_payload_in   = 1'b0;
         long_form_in    = 1'b1;
         size_accum_in   = {hdr_accum[55:0], stream_byte};
         header_count_in = hdr_count + 4'd1;
         remaining_in    = 64'd0;
      end else if (hdr_count == lpfd_pkg::LONG_FLAGS_COUNT) begin
         do_finish = 1'b1;
      end else begin
         do_first = 1'b1;
      end

      if (do_first) begin
         in_payload_in   = 1'b0;
         long_form_in    = (stream_byte == lpfd_pkg::LONG_MARK);
         size_accum_in   = (stream_byte == lpfd_pkg::LONG_MARK) ? 64'd0
                                                                : {56'd0, stream_byte};
         header_count_in = 4'd1;
         remaining_in    = 64'd0;
      end

      if (do_finish) begin
         in_payload_in   = 1'b0;
         header_count_in = 4'd0;
         long_form_in    = 1'b0;
         size_accum_in   = 64'd0;
         remaining_in    = 64'd0;
         result.valid    = 1'b1;
         if (hdr_accum == 64'd0) begin
            result.kind = lpfd_pkg::KIND_ERROR;
         end else begin
            result.kind   = lpfd_pkg::KIND_HEADER;
            result.length = hdr_accum - 64'd1;
            result.more   = (stream_byte == lpfd_pkg::FLAG_MORE);
            result.last   = (hdr_accum == 64'd1);
            if (hdr_accum != 64'd1) begin
               in_payload_in = 1'b1;
               remaining_in  = hdr_accum - 64'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff   <= 1'b0;
         header_count_ff <= 4'd0;
         long_form_ff    <= 1'b0;
         size_accum_ff   <= 64'd0;
         remaining_ff    <= 64'd0;
      end else if (step) begin
         in_payload_ff   <= in_payload_in;
         header_count_ff <= header_count_in;
         long_form_ff    <= long_form_in;
         size_accum_ff   <= size_accum_in;
         remaining_ff    <= remaining_in;
      end
   end

   `LPFD_ASSERT_SAME(a_payload_has_bytes, clock, reset, in_payload_ff, remaining_ff != 64'd0)
   `LPFD_ASSERT_SAME(a_count_in_range, clock, reset, !in_payload_ff,
                     header_count_ff <= lpfd_pkg::LONG_FLAGS_COUNT)
   `LPFD_ASSERT_SAME(a_short_count, clock, reset, !in_payload_ff && !long_form_ff,
                     header_count_ff <= lpfd_pkg::SHORT_FLAGS_COUNT)

endmodule

>>> src/length_prefixed_frame_deframer_unit.sv
// Top level of the length-prefixed frame deframer.
`timescale 1ns / 1ps
`include "length_prefixed_frame_deframer_unit_assert.svh"
// Usage:
//   req_* carries the raw framed byte stream, one byte per beat.
//   rsp_* carries events: a header (payload length and more flag), each
//   payload byte with tlast on the final one, or a zero-size error.
//   Size bytes and the first byte of a long-form size produce no event.
// Path: an accepted byte waits in the input register, is decoded, then
//   loads the result register that drives rsp_*; a stall can hold it
//   in the input register while the result register is full.
// Throughput: one byte per cycle sustained while rsp_tready stays high;
//   the byte decode between the input and result registers is a single pass.
// Reset: synchronous; clears the valid flags of both registers and the
//   parse state, so the next byte is read as the first byte of a header.
// Stall: when rsp_tready is low the result register holds; the input
//   register then fills and req_tready drops until the result drains.
//   Bytes that make no event keep moving while the result waits.
module length_prefixed_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [7:0] payload_byte, [71:8] frame_length,
                                    // [72] more_flag, [79:73] zero
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   output logic        rsp_tlast    // last_of_frame
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   lpfd_pkg::result_type rsp_ff;
   lpfd_pkg::result_type parse;
   logic                 out_free;
   logic                 in_moves;

   lpfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (in_moves),
      .stream_byte (in_byte_ff),
      .result      (parse)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_moves   = in_valid_ff && (!parse.valid || out_free);
   assign req_tready = !in_valid_ff || in_moves;

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (in_moves && parse.valid) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) in_byte_ff <= req_tdata;
      if (in_moves && parse.valid) rsp_ff <= parse;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.more, rsp_ff.length, rsp_ff.payload};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

   `LPFD_ASSERT_SAME(a_error_clean, clock, reset,
                     rsp_tvalid && rsp_tuser == lpfd_pkg::KIND_ERROR,
                     rsp_tdata == 80'd0 && !rsp_tlast)
   `LPFD_ASSERT_SAME(a_empty_header_last, clock, reset,
                     rsp_tvalid && rsp_tuser == lpfd_pkg::KIND_HEADER,
                     rsp_tlast == (rsp_tdata[71:8] == 64'd0))
   `LPFD_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !in_moves,
                     in_valid_ff && $stable(in_byte_ff))

endmodule
